// File: rtl/rbr_pkg.sv
// rbr_pkg: shared constants and types of the ring buffer with rewind
// no dependencies; used by rbr_ctrl, the top level and rbr_checker
package rbr_pkg;

    localparam int DEPTH_DEF     = 256;
    localparam int WORD_BITS_DEF = 32;

    localparam int ACT_W    = 2;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 9;
    localparam int CFG_W    = 9;
    localparam int UNREAD_W = 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_REWIND = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

endpackage

// File: rtl/rbr_ram.sv
// rbr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module rbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rbr_ctrl.sv
// rbr_ctrl: pointer and capacity registers, request decode and result register
// depends on rbr_pkg; drives the word store ram in the top level
module rbr_ctrl #(
    parameter int DEPTH = rbr_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [rbr_pkg::ACT_W-1:0]    i_action,
    input  logic [rbr_pkg::CNT_W-1:0]    i_rewind_count,
    input  logic                         i_cfg_wr_en,
    input  logic [rbr_pkg::CFG_W-1:0]    i_cfg_wr_data,
    output logic                         o_ram_we,
    output logic [$clog2(DEPTH)-1:0]     o_ram_waddr,
    output logic                         o_ram_re,
    output logic [$clog2(DEPTH)-1:0]     o_ram_raddr,
    output logic                         o_valid,
    output logic                         o_status,
    output logic                         o_rd_sel,
    output logic [rbr_pkg::UNREAD_W-1:0] o_unread_count
);

    localparam int PW    = $clog2(DEPTH);
    localparam int CAP_W = $clog2(DEPTH + 1);
    localparam int MW    = (CAP_W > rbr_pkg::CFG_W) ? CAP_W : rbr_pkg::CFG_W;
    localparam int UW    = rbr_pkg::UNREAD_W;

    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_wp, n_wp;
    logic [CAP_W-1:0] r_cap, n_cap;
    logic             r_valid, n_valid;
    logic             r_status, n_status;
    logic             r_rd_sel, n_rd_sel;
    logic [UW-1:0]    r_unread, n_unread;

    logic [CAP_W-1:0] wp_inc;
    logic [CAP_W-1:0] unread_now;
    logic [MW:0]      rew_sum;
    logic [MW-1:0]    cnt_ext;
    logic [MW-1:0]    cap_ext;
    logic [MW-1:0]    cfg_ext;

    // (wp - rp) modulo cap, pointers below cap while cap is nonzero
    function automatic logic [CAP_W-1:0] unread_of(
        input logic [PW-1:0]    wp,
        input logic [PW-1:0]    rp,
        input logic [CAP_W-1:0] cap
    );
        logic [CAP_W:0] diff;
        diff = (wp >= rp) ? ((CAP_W+1)'(wp) - (CAP_W+1)'(rp))
                          : ((CAP_W+1)'(wp) + (CAP_W+1)'(cap) - (CAP_W+1)'(rp));
        return CAP_W'(diff);
    endfunction

    always_comb begin
        cnt_ext    = MW'(i_rewind_count);
        cap_ext    = MW'(r_cap);
        cfg_ext    = MW'(i_cfg_wr_data);
        wp_inc     = CAP_W'(r_wp) + CAP_W'(1);
        unread_now = unread_of(r_wp, r_rp, r_cap);
        // rp + cap - count lies below twice cap once count <= cap
        rew_sum    = (MW+1)'(r_rp) + (MW+1)'(r_cap) - (MW+1)'(cnt_ext);
        if (rew_sum >= (MW+1)'(r_cap)) begin
            rew_sum = rew_sum - (MW+1)'(r_cap);
        end

        n_rp     = r_rp;
        n_wp     = r_wp;
        n_cap    = r_cap;
        n_valid  = 1'b0;
        n_status = 1'b0;
        n_rd_sel = 1'b0;
        o_ram_we = 1'b0;
        o_ram_re = 1'b0;

        if (i_cfg_wr_en) begin
            n_cap = (cfg_ext > MW'(DEPTH)) ? CAP_W'(DEPTH) : CAP_W'(cfg_ext);
            n_rp  = '0;
            n_wp  = '0;
        end else if (i_accept) begin
            n_valid = 1'b1;
            case (rbr_pkg::t_action'(i_action))
                rbr_pkg::ACT_WRITE: begin
                    if (r_cap == '0) begin
                        n_status = 1'b1;
                    end else begin
                        o_ram_we = 1'b1;
                        n_wp     = (wp_inc == r_cap) ? '0 : PW'(wp_inc);
                    end
                end
                rbr_pkg::ACT_READ: begin
                    if (r_cap == '0 || unread_now == '0) begin
                        n_status = 1'b1;
                    end else begin
                        o_ram_re = 1'b1;
                        n_rd_sel = 1'b1;
                        n_rp     = (CAP_W'(r_rp) + CAP_W'(1) == r_cap)
                                   ? '0 : r_rp + PW'(1);
                    end
                end
                rbr_pkg::ACT_REWIND: begin
                    if (cnt_ext > cap_ext) begin
                        n_status = 1'b1;
                    end else if (r_cap != '0) begin
                        n_rp = PW'(rew_sum);
                    end
                end
                rbr_pkg::ACT_CLEAR: begin
                    n_rp = r_wp;
                end
                default: begin
                    n_rp = r_rp;
                end
            endcase
        end

        n_unread = UW'(unread_of(n_wp, n_rp, n_cap));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_cap   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            r_cap   <= n_cap;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_rd_sel <= n_rd_sel;
        r_unread <= n_unread;
    end

    assign o_ram_waddr    = r_wp;
    assign o_ram_raddr    = r_rp;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_rd_sel       = r_rd_sel;
    assign o_unread_count = r_unread;

endmodule

// File: rtl/ring_buffer_with_rewind_unit.sv
// ring_buffer_with_rewind_unit: top level of the ring buffer with rewind
// depends on rbr_pkg, rbr_ram and rbr_ctrl
//
// A request (action, write data, rewind count) is taken at a rising edge with
// start high and busy low. busy is never raised: a request can be taken in
// every cycle, so the throughput is one item per clock, but a request taken
// while i_cfg_wr_en is high is lost. Every other request gives exactly one
// result (status, read data, unread count), shown for one cycle with o_valid,
// in the cycle after the request is taken. The pointer update is a single
// compare-and-wrap step done in the cycle the request is taken; the read word
// comes from the registered read port of the word store ram. The capacity
// register write (i_cfg_wr_en) sets both pointers to zero; the user must make
// it only while no request is in flight, which the block does not enforce.
// Synchronous active-low reset clears pointers, capacity (no buffer) and
// o_valid; the word store is not cleared and holds garbage until written.
// The receiver cannot stall: every result must be taken in its cycle.
module ring_buffer_with_rewind_unit #(
    parameter int DEPTH     = rbr_pkg::DEPTH_DEF,
    parameter int WORD_BITS = rbr_pkg::WORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rbr_pkg::ACT_W-1:0]    i_action,
    input  logic [rbr_pkg::DATA_W-1:0]   i_write_data,
    input  logic [rbr_pkg::CNT_W-1:0]    i_rewind_count,
    input  logic                         i_cfg_wr_en,
    input  logic [rbr_pkg::CFG_W-1:0]    i_cfg_wr_data,
    output logic                         o_valid,
    output logic                         o_status,
    output logic [rbr_pkg::DATA_W-1:0]   o_read_data,
    output logic [rbr_pkg::UNREAD_W-1:0] o_unread_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int DW = rbr_pkg::DATA_W;

    logic                 accept;
    logic                 ram_we;
    logic                 ram_re;
    logic [PW-1:0]        ram_waddr;
    logic [PW-1:0]        ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_q;
    logic                 rd_sel;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign ram_wdata = WORD_BITS'(i_write_data);

    rbr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_rewind_count (i_rewind_count),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_rd_sel       (rd_sel),
        .o_unread_count (o_unread_count)
    );

    rbr_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // only a successful read shows the stored word
    assign o_read_data = rd_sel ? DW'(ram_q) : '0;

endmodule

// File: rtl/rbr_checker.sv
// rbr_checker: port-level assertions for ring_buffer_with_rewind_unit
// depends on rbr_pkg; bound to the top level below
module rbr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [rbr_pkg::ACT_W-1:0]    i_action,
    input logic [rbr_pkg::CNT_W-1:0]    i_rewind_count,
    input logic                         o_valid,
    input logic                         o_status,
    input logic [rbr_pkg::DATA_W-1:0]   o_read_data,
    input logic [rbr_pkg::UNREAD_W-1:0] o_unread_count
);

    // one result per item, in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_valid == $past(start && !busy)))
        else $error("result strobe does not follow item by one cycle");

    a_err_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_read_data == '0))
        else $error("failed request returned nonzero read data");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(start && !busy && i_action == rbr_pkg::ACT_CLEAR))
        |-> (o_valid && !o_status && o_unread_count == '0))
        else $error("clear did not leave an empty buffer");

    a_rewind_zero_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(start && !busy && i_action == rbr_pkg::ACT_REWIND
                                 && i_rewind_count == '0))
        |-> (o_valid && !o_status))
        else $error("rewind by zero reported an error");

    a_write_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(start && !busy && i_action == rbr_pkg::ACT_WRITE))
        |-> (o_read_data == '0))
        else $error("write returned read data");

endmodule

bind ring_buffer_with_rewind_unit rbr_checker u_rbr_checker (.*);
